// ===== rtl/pan_tilt_face_tracking_servo_core_defines.svh =====
// Assertion macros for the pan/tilt face tracking servo core.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef PAN_TILT_FACE_TRACKING_SERVO_CORE_DEFINES_SVH
`define PAN_TILT_FACE_TRACKING_SERVO_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTFTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptfts assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTFTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptfts assertion failed");

`endif

// ===== rtl/ptfts_pkg.sv =====
// Shared types, widths and constants of the pan/tilt face tracking servo core.
// No dependencies; every other RTL file but the defines header refers to this package by scoped names.
package ptfts_pkg;

    // Field widths.
    localparam int COORD_W    = 12;
    localparam int DEAD_W     = 16;
    localparam int DEAD_FRAC  = 16;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Internal widths.
    localparam int CENTER_W = 14;
    localparam int NUM_W    = 14;
    localparam int MAG_W    = 13;
    localparam int DIVD_W   = 18;
    localparam int DZP_W    = DEAD_W + COORD_W;
    localparam int STEPS_W  = 21;
    localparam int SUM_W    = 23;
    localparam int CNT_W    = 5;

    // Scaling: steps = trunc(trunc(20*|offset|) * 4096 / 360) = trunc(coarse * 512 / 45).
    localparam int SCALE_SH    = 9;
    localparam int SCALE_DIV   = 45;
    localparam int RECIP_W     = 27;
    localparam int PROD_W      = DIVD_W + RECIP_W;
    localparam int RECIP_SHIFT = 32 - SCALE_SH;
    localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443717;
    localparam int DIV_STEPS   = DIVD_W;

    localparam logic [POS_W-1:0] POS_MAX = 12'd2048;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST   = 12'd640;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST  = 12'd640;
    localparam logic [COORD_W-1:0] CLIP_LIMIT_RST    = 12'd640;
    localparam logic [DEAD_W-1:0]  DEAD_ZONE_RST     = 16'd6554;
    localparam logic [COORD_W-1:0] REPEAT_WINDOW_RST = 12'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_CLIP_LIMIT    = 3'd2,
        REG_DEAD_ZONE     = 3'd3,
        REG_REPEAT_WINDOW = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic [COORD_W-1:0]        box_width;
        logic [COORD_W-1:0]        box_height;
        logic                      first_of_frame;
    } box_t;

    typedef struct packed {
        logic             commanded;
        logic [POS_W-1:0] pan_angle;
        logic [POS_W-1:0] tilt_angle;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] frame_width;
        logic [COORD_W-1:0] frame_height;
        logic [COORD_W-1:0] clip_limit;
        logic [DEAD_W-1:0]  dead_zone;
        logic [COORD_W-1:0] repeat_window;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic decide;
        logic dead;
        logic div_step;
        logic recip;
        logic fix;
        logic update;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
    } stat_t;

endpackage

// ===== rtl/ptfts_axis.sv =====
// One axis lane: dead-zone test, serial divider and scaling to servo steps.
// Depends on ptfts_pkg; instantiated twice by ptfts_dp.
module ptfts_axis (
    input  logic                                clk,
    input  ptfts_pkg::cmd_t                     cmd,
    input  logic signed [ptfts_pkg::NUM_W-1:0]  num,
    input  logic [ptfts_pkg::COORD_W-1:0]       den,
    input  logic [ptfts_pkg::DEAD_W-1:0]        dead_zone,
    output logic                                neg,
    output logic [ptfts_pkg::STEPS_W-1:0]       steps
);

    logic                              neg_reg;
    logic [ptfts_pkg::MAG_W-1:0]       mag_reg;
    logic [ptfts_pkg::COORD_W-1:0]     den_reg;
    logic                              den_zero_reg;
    logic [ptfts_pkg::DZP_W-1:0]       dzp_reg;
    logic                              quiet_reg;
    logic [ptfts_pkg::COORD_W-1:0]     rem_reg;
    logic [ptfts_pkg::DIVD_W-1:0]      quo_reg;
    logic [ptfts_pkg::PROD_W-1:0]      prod_reg;
    logic [ptfts_pkg::STEPS_W-1:0]     steps_reg;

    logic [ptfts_pkg::NUM_W-1:0]       num_abs;
    logic [ptfts_pkg::DIVD_W-1:0]      gain;
    logic [ptfts_pkg::COORD_W:0]       shifted;
    logic [ptfts_pkg::COORD_W+1:0]     trial;
    logic                              fits;
    logic                              below;
    logic [ptfts_pkg::STEPS_W-1:0]     q_est;
    logic [ptfts_pkg::RECIP_W-1:0]     est45;
    logic [ptfts_pkg::RECIP_W-1:0]     scaled;
    logic [ptfts_pkg::RECIP_W-1:0]     rem_s;
    logic                              corr;

    always_comb
    begin
        num_abs = num[ptfts_pkg::NUM_W-1] ? ptfts_pkg::NUM_W'(-num)
                                          : ptfts_pkg::NUM_W'(num);
        // 20 * magnitude as two shifted adds.
        gain    = ptfts_pkg::DIVD_W'({mag_reg, 4'b0000})
                + ptfts_pkg::DIVD_W'({mag_reg, 2'b00});
        shifted = {rem_reg, quo_reg[ptfts_pkg::DIVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
        fits    = !trial[ptfts_pkg::COORD_W+1];
        below   = ({mag_reg, {ptfts_pkg::DEAD_FRAC{1'b0}}}
                  < {1'b0, dzp_reg});
        // The reciprocal estimate is exact or one low; one compare fixes it.
        q_est   = prod_reg[ptfts_pkg::RECIP_SHIFT +: ptfts_pkg::STEPS_W];
        est45   = ptfts_pkg::RECIP_W'(q_est)
                * ptfts_pkg::RECIP_W'(ptfts_pkg::SCALE_DIV);
        scaled  = {quo_reg, {ptfts_pkg::SCALE_SH{1'b0}}};
        rem_s   = scaled - est45;
        corr    = (rem_s >= ptfts_pkg::RECIP_W'(ptfts_pkg::SCALE_DIV));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            neg_reg      <= num[ptfts_pkg::NUM_W-1];
            mag_reg      <= num_abs[ptfts_pkg::MAG_W-1:0];
            den_reg      <= den;
            den_zero_reg <= (den == '0);
        end
        if (cmd.dead)
        begin
            dzp_reg <= ptfts_pkg::DZP_W'(dead_zone) * ptfts_pkg::DZP_W'(den_reg);
            rem_reg <= '0;
            quo_reg <= gain;
        end
        if (cmd.div_step)
        begin
            rem_reg <= fits ? trial[ptfts_pkg::COORD_W-1:0]
                            : shifted[ptfts_pkg::COORD_W-1:0];
            quo_reg <= {quo_reg[ptfts_pkg::DIVD_W-2:0], fits};
        end
        if (cmd.recip)
        begin
            prod_reg  <= ptfts_pkg::PROD_W'(quo_reg) * ptfts_pkg::PROD_W'(ptfts_pkg::RECIP_45);
            quiet_reg <= den_zero_reg | below;
        end
        if (cmd.fix)
        begin
            steps_reg <= quiet_reg ? '0 : q_est + ptfts_pkg::STEPS_W'(corr);
        end
    end

    assign neg   = neg_reg;
    assign steps = steps_reg;

endmodule

// ===== rtl/ptfts_dp.sv =====
// Datapath: box clipping, repeat-window test, tracked state and result register.
// Depends on ptfts_pkg and ptfts_axis.
module ptfts_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ptfts_pkg::cmd_t    cmd,
    input  ptfts_pkg::cfg_t    cfg,
    input  ptfts_pkg::box_t    box,
    output ptfts_pkg::stat_t   stat,
    output ptfts_pkg::result_t result
);

    ptfts_pkg::box_t                  box_reg;
    ptfts_pkg::result_t               result_reg;
    logic [ptfts_pkg::CENTER_W-1:0]   center_reg;
    logic [ptfts_pkg::COORD_W-1:0]    bottom_reg;
    logic [ptfts_pkg::CENTER_W-1:0]   last_reg;
    logic [ptfts_pkg::POS_W-1:0]      pan_reg;
    logic [ptfts_pkg::POS_W-1:0]      tilt_reg;
    logic                             skipping_reg;
    logic                             commanded_reg;

    logic [ptfts_pkg::COORD_W-1:0]    x_c;
    logic [ptfts_pkg::COORD_W-1:0]    y_c;
    logic [ptfts_pkg::COORD_W:0]      sum_x;
    logic [ptfts_pkg::COORD_W:0]      sum_y;
    logic [ptfts_pkg::COORD_W:0]      lim;
    logic [ptfts_pkg::CENTER_W-1:0]   center_next;
    logic [ptfts_pkg::COORD_W-1:0]    bottom_next;
    logic [ptfts_pkg::CENTER_W:0]     diff_s;
    logic [ptfts_pkg::CENTER_W-1:0]   diff;
    logic                             in_window;
    logic                             skip;
    logic signed [ptfts_pkg::NUM_W-1:0] num_x;
    logic signed [ptfts_pkg::NUM_W-1:0] num_y;
    logic                             neg_x;
    logic                             neg_y;
    logic [ptfts_pkg::STEPS_W-1:0]    steps_x;
    logic [ptfts_pkg::STEPS_W-1:0]    steps_y;
    logic signed [ptfts_pkg::SUM_W-1:0] pan_sum;
    logic signed [ptfts_pkg::SUM_W-1:0] tilt_sum;

    function automatic logic [ptfts_pkg::POS_W-1:0] saturate(
        input logic signed [ptfts_pkg::SUM_W-1:0] v
    );
        logic [ptfts_pkg::POS_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(ptfts_pkg::SUM_W'(ptfts_pkg::POS_MAX)))
            r = ptfts_pkg::POS_MAX;
        else
            r = v[ptfts_pkg::POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [ptfts_pkg::SUM_W-1:0] apply(
        input logic [ptfts_pkg::POS_W-1:0]   pos,
        input logic                          neg,
        input logic [ptfts_pkg::STEPS_W-1:0] steps
    );
        logic signed [ptfts_pkg::SUM_W-1:0] p;
        logic signed [ptfts_pkg::SUM_W-1:0] s;
        p = $signed(ptfts_pkg::SUM_W'(pos));
        s = $signed(ptfts_pkg::SUM_W'(steps));
        return neg ? p - s : p + s;
    endfunction

    always_comb
    begin
        // Clip: negative edges go to zero, right and bottom edges to the limit.
        x_c   = box_reg.box_x[ptfts_pkg::COORD_W-1] ? '0 : $unsigned(box_reg.box_x);
        y_c   = box_reg.box_y[ptfts_pkg::COORD_W-1] ? '0 : $unsigned(box_reg.box_y);
        lim   = {1'b0, cfg.clip_limit};
        sum_x = {1'b0, x_c} + {1'b0, box_reg.box_width};
        sum_y = {1'b0, y_c} + {1'b0, box_reg.box_height};
        center_next = (sum_x > lim)
                    ? ptfts_pkg::CENTER_W'(x_c) + ptfts_pkg::CENTER_W'(cfg.clip_limit)
                    : ptfts_pkg::CENTER_W'(x_c) + ptfts_pkg::CENTER_W'(sum_x);
        bottom_next = (sum_y > lim) ? cfg.clip_limit : sum_y[ptfts_pkg::COORD_W-1:0];

        diff_s    = {1'b0, last_reg} - {1'b0, center_reg};
        diff      = diff_s[ptfts_pkg::CENTER_W] ? ptfts_pkg::CENTER_W'(-diff_s)
                                                : diff_s[ptfts_pkg::CENTER_W-1:0];
        in_window = (diff < {1'b0, cfg.repeat_window, 1'b0});
        skip      = (skipping_reg & ~box_reg.first_of_frame) | in_window;

        num_x = $signed(center_reg - ptfts_pkg::NUM_W'(cfg.frame_width));
        num_y = $signed({1'b0, bottom_reg, 1'b0} - ptfts_pkg::NUM_W'(cfg.frame_height));

        pan_sum  = apply(pan_reg, neg_x, steps_x);
        tilt_sum = apply(tilt_reg, neg_y, steps_y);
    end

    ptfts_axis u_axis_x (
        .clk       (clk),
        .cmd       (cmd),
        .num       (num_x),
        .den       (cfg.frame_width),
        .dead_zone (cfg.dead_zone),
        .neg       (neg_x),
        .steps     (steps_x)
    );

    ptfts_axis u_axis_y (
        .clk       (clk),
        .cmd       (cmd),
        .num       (num_y),
        .den       (cfg.frame_height),
        .dead_zone (cfg.dead_zone),
        .neg       (neg_y),
        .steps     (steps_y)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            box_reg <= box;
        if (cmd.prep)
        begin
            center_reg <= center_next;
            bottom_reg <= bottom_next;
        end
        if (cmd.decide)
            commanded_reg <= ~skip;
        if (cmd.out_load)
            result_reg <= '{commanded: commanded_reg, pan_angle: pan_reg,
                            tilt_angle: tilt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skipping_reg <= 1'b0;
            last_reg     <= '0;
            pan_reg      <= '0;
            tilt_reg     <= '0;
        end
        else
        begin
            if (cmd.decide)
                skipping_reg <= skip;
            if (cmd.update)
            begin
                last_reg <= center_reg;
                pan_reg  <= saturate(pan_sum);
                tilt_reg <= saturate(tilt_sum);
            end
        end
    end

    assign stat.skip = skip;
    assign result    = result_reg;

endmodule

// ===== rtl/ptfts_ctrl.sv =====
// Controller: one-hot sequencer that steps one box through the datapath.
// Depends on ptfts_pkg; drives ptfts_dp through the command struct.
module ptfts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             box_valid,
    output logic             box_stall,
    output logic             result_valid,
    input  logic             result_stall,
    input  ptfts_pkg::stat_t stat,
    output ptfts_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PREP   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_DEAD   = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_RECIP  = 9'b000100000,
        S_FIX    = 9'b001000000,
        S_UPDATE = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [ptfts_pkg::CNT_W-1:0]   cnt_reg;
    logic [ptfts_pkg::CNT_W-1:0]   cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (box_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.skip ? S_DONE : S_DEAD;
            end
            S_DEAD:
            begin
                cmd.dead   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ptfts_pkg::CNT_W'(ptfts_pkg::DIV_STEPS - 1))
                    state_next = S_RECIP;
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign box_stall    = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/pan_tilt_face_tracking_servo_core.sv =====
// Top level of the pan/tilt face tracking servo core: configuration registers,
// controller and datapath. Depends on ptfts_pkg, ptfts_ctrl, ptfts_dp and the defines header.
//
//   channel  direction  handshake              payload
//   box      in         box_valid / box_stall  box (ptfts_pkg::box_t)
//   result   out        result_valid / stall   result (ptfts_pkg::result_t)
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A box that issues new angles passes prep, decide, dead-zone, the 18-step divider that
// both axes run at once, reciprocal, fix, update and done before the core accepts again;
// a skipped box goes from decide to done. Reset (rst_n low, asynchronous) loads the
// configuration defaults and zeroes both angles, the tracked center and the frame skip
// flag. The result register parts the two sides: a new box is taken while the last
// result still waits, and only the final hand-off waits on result_stall.
`include "pan_tilt_face_tracking_servo_core_defines.svh"

module pan_tilt_face_tracking_servo_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               box_valid,
    output logic                               box_stall,
    input  ptfts_pkg::box_t                    box,
    output logic                               result_valid,
    input  logic                               result_stall,
    output ptfts_pkg::result_t                 result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptfts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptfts_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ptfts_pkg::cfg_t  cfg_reg;
    ptfts_pkg::cfg_t  cfg_next;
    ptfts_pkg::cmd_t  cmd;
    ptfts_pkg::stat_t stat;
    logic             angles_in_range;

    // Configuration writes are always taken; the user must write the register set only while no
    // request is in flight, which the core does not enforce, so the datapath reads it directly.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ptfts_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_data[ptfts_pkg::COORD_W-1:0];
                ptfts_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_data[ptfts_pkg::COORD_W-1:0];
                ptfts_pkg::REG_CLIP_LIMIT:
                    cfg_next.clip_limit = cfg_data[ptfts_pkg::COORD_W-1:0];
                ptfts_pkg::REG_DEAD_ZONE:
                    cfg_next.dead_zone = cfg_data[ptfts_pkg::DEAD_W-1:0];
                ptfts_pkg::REG_REPEAT_WINDOW:
                    cfg_next.repeat_window = cfg_data[ptfts_pkg::COORD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= ptfts_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= ptfts_pkg::FRAME_HEIGHT_RST;
            cfg_reg.clip_limit    <= ptfts_pkg::CLIP_LIMIT_RST;
            cfg_reg.dead_zone     <= ptfts_pkg::DEAD_ZONE_RST;
            cfg_reg.repeat_window <= ptfts_pkg::REPEAT_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller sequences each request; the datapath holds all arithmetic
    // and the tracked state.
    ptfts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .box_valid    (box_valid),
        .box_stall    (box_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    ptfts_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .box    (box),
        .stat   (stat),
        .result (result)
    );

    assign angles_in_range = (result.pan_angle <= ptfts_pkg::POS_MAX)
                          && (result.tilt_angle <= ptfts_pkg::POS_MAX);

    // Reported angles always sit inside the servo range.
    `PTFTS_ASSERT_SAME(a_angle_range, result_valid, angles_in_range)
    // Once a request is taken the core is busy on the next cycle.
    `PTFTS_ASSERT_NEXT(a_busy_after_accept, box_valid && !box_stall, box_stall)
    // The divider steps run without a gap straight into the reciprocal stage.
    `PTFTS_ASSERT_NEXT(a_div_to_recip, cmd.div_step, cmd.div_step || cmd.recip)
    // A new result never overwrites one that is still waiting.
    `PTFTS_ASSERT_SAME(a_load_when_free, cmd.out_load, !result_valid || !result_stall)

endmodule
